FILE: src/fixed_point_q24_8_alu_unit_defines.svh
// assertion macros shared by the checker of the fixed-point alu
// no dependencies; expects clk and rst_n in the including scope
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH

// checked only outside reset
`define FXA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define FXA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/fxa_pkg.sv
// types and codes of the fixed-point alu
// no dependencies
package fxa_pkg;

  typedef enum logic [3:0] {
    MODE_ADD     = 4'd0,
    MODE_SUB     = 4'd1,
    MODE_MUL     = 4'd2,
    MODE_DIV     = 4'd3,
    MODE_CMP     = 4'd4,
    MODE_MIN     = 4'd5,
    MODE_MAX     = 4'd6,
    MODE_INC     = 4'd7,
    MODE_INT2FX  = 4'd8,
    MODE_FX2INT  = 4'd9
  } mode_t;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // control and flags that travel with every transaction
  typedef struct packed {
    logic       valid;
    logic [3:0] mode;
    logic       lt;
    logic       eq;
    logic       gt;
    logic       sat;
    logic       dz;
    logic       neg;
  } ctrl_t;

endpackage

FILE: src/fxa_front.sv
// input register, simple operations, multiplier and divider setup
// depends on fxa_pkg
module fxa_front import fxa_pkg::*; #(
  parameter int FRACT_BITS = 8,
  parameter int W = 32 + FRACT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [3:0]        in_mode,
  input  logic [31:0]       in_operand_a,
  input  logic [31:0]       in_operand_b,
  output ctrl_t             ctrl_o,
  output logic [31:0]       res_o,
  output logic [31:0]       den_o,
  output logic [W-1:0]      num_o
);

  logic        v0_r;
  logic [3:0]  mode0_r;
  logic [31:0] a0_r, b0_r;

  ctrl_t       ctrl1_r, ctrl1_nxt;
  logic [31:0] res1_r, res1_nxt;
  logic [63:0] prod1_r, prod1_nxt;
  logic [31:0] den1_r, den1_nxt;
  logic [W-1:0] num1_r, num1_nxt;

  logic [31:0] abs_a, abs_b;
  logic [63:0] mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      ctrl1_r <= '0;
    end else if (en) begin
      v0_r <= in_valid;
      ctrl1_r <= ctrl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode0_r <= in_mode;
      a0_r <= in_operand_a;
      b0_r <= in_operand_b;
      res1_r <= res1_nxt;
      prod1_r <= prod1_nxt;
      den1_r <= den1_nxt;
      num1_r <= num1_nxt;
    end
  end

  always_comb begin
    abs_a = a0_r[31] ? (32'd0 - a0_r) : a0_r;
    abs_b = b0_r[31] ? (32'd0 - b0_r) : b0_r;
    prod1_nxt = 64'(abs_a) * 64'(abs_b);
    den1_nxt = abs_b;
    num1_nxt = {abs_a, {FRACT_BITS{1'b0}}};
    ctrl1_nxt.valid = v0_r;
    ctrl1_nxt.mode = mode0_r;
    ctrl1_nxt.lt = $signed(a0_r) < $signed(b0_r);
    ctrl1_nxt.eq = a0_r == b0_r;
    ctrl1_nxt.gt = $signed(a0_r) > $signed(b0_r);
    ctrl1_nxt.sat = 1'b0;
    ctrl1_nxt.dz = (mode0_r == MODE_DIV) && (b0_r == 32'd0);
    ctrl1_nxt.neg = a0_r[31] ^ b0_r[31];
    case (mode0_r)
      MODE_ADD:    res1_nxt = a0_r + b0_r;
      MODE_SUB:    res1_nxt = a0_r - b0_r;
      MODE_MIN:    res1_nxt = ctrl1_nxt.lt ? a0_r : b0_r;
      MODE_MAX:    res1_nxt = ctrl1_nxt.gt ? a0_r : b0_r;
      MODE_INC:    res1_nxt = a0_r + 32'd1;
      MODE_INT2FX: res1_nxt = a0_r << FRACT_BITS;
      MODE_FX2INT: res1_nxt = 32'($signed(a0_r) >>> FRACT_BITS);
      default:     res1_nxt = 32'd0;
    endcase
  end

  // multiply rounding and saturation after the product register
  always_comb begin
    ctrl_o = ctrl1_r;
    res_o = res1_r;
    mag = (prod1_r + (64'd1 << (FRACT_BITS - 1))) >> FRACT_BITS;
    if (ctrl1_r.mode == MODE_MUL) begin
      if (ctrl1_r.neg) begin
        if (mag > 64'(SAT_NEG)) begin
          res_o = SAT_NEG;
          ctrl_o.sat = 1'b1;
        end else begin
          res_o = 32'd0 - mag[31:0];
        end
      end else begin
        if (mag > 64'(SAT_POS)) begin
          res_o = SAT_POS;
          ctrl_o.sat = 1'b1;
        end else begin
          res_o = mag[31:0];
        end
      end
    end
  end

  assign den_o = den1_r;
  assign num_o = num1_r;

endmodule

FILE: src/fxa_div_cell.sv
// one restoring-division cell: settles one quotient bit per transaction
// depends on fxa_pkg
module fxa_div_cell import fxa_pkg::*; #(
  parameter int W = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  ctrl_t         ctrl_i,
  input  logic [31:0]   res_i,
  input  logic [31:0]   den_i,
  input  logic [31:0]   rem_i,
  input  logic [W-1:0]  nq_i,
  output ctrl_t         ctrl_o,
  output logic [31:0]   res_o,
  output logic [31:0]   den_o,
  output logic [31:0]   rem_o,
  output logic [W-1:0]  nq_o
);

  ctrl_t        ctrl_r;
  logic [31:0]  res_r, den_r, rem_r, rem_nxt;
  logic [W-1:0] nq_r, nq_nxt;
  logic [32:0]  rsh, diff;
  logic         ge;

  always_comb begin
    rsh = {rem_i, nq_i[W-1]};
    diff = rsh - {1'b0, den_i};
    ge = rsh >= {1'b0, den_i};
    rem_nxt = ge ? diff[31:0] : rsh[31:0];
    // numerator bits shift out at the top, quotient bits enter at the bottom
    nq_nxt = {nq_i[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_i;
      den_r <= den_i;
      rem_r <= rem_nxt;
      nq_r <= nq_nxt;
    end
  end

  assign ctrl_o = ctrl_r;
  assign res_o = res_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign nq_o = nq_r;

endmodule

FILE: src/fxa_back.sv
// quotient rounding, saturation and the output register
// depends on fxa_pkg
module fxa_back import fxa_pkg::*; #(
  parameter int W = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  ctrl_t         ctrl_i,
  input  logic [31:0]   res_i,
  input  logic [31:0]   den_i,
  input  logic [31:0]   rem_i,
  input  logic [W-1:0]  q_i,
  output logic          out_valid,
  output logic [31:0]   out_result,
  output logic          out_a_less,
  output logic          out_a_equal,
  output logic          out_a_greater,
  output logic          out_saturated,
  output logic          out_divide_by_zero
);

  logic        valid_r;
  logic [31:0] res_r, res_nxt;
  logic        lt_r, eq_r, gt_r, sat_r, dz_r, sat_nxt;
  logic        rnd;
  logic [W:0]  qr;

  always_comb begin
    rnd = {rem_i, 1'b0} >= {1'b0, den_i};
    qr = {1'b0, q_i} + {{W{1'b0}}, rnd};
    res_nxt = res_i;
    sat_nxt = ctrl_i.sat;
    if (ctrl_i.mode == MODE_DIV) begin
      if (ctrl_i.dz) begin
        res_nxt = 32'd0;
      end else if (ctrl_i.neg) begin
        if (qr > (W+1)'(SAT_NEG)) begin
          res_nxt = SAT_NEG;
          sat_nxt = 1'b1;
        end else begin
          res_nxt = 32'd0 - qr[31:0];
        end
      end else begin
        if (qr > (W+1)'(SAT_POS)) begin
          res_nxt = SAT_POS;
          sat_nxt = 1'b1;
        end else begin
          res_nxt = qr[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      lt_r <= ctrl_i.lt;
      eq_r <= ctrl_i.eq;
      gt_r <= ctrl_i.gt;
      sat_r <= sat_nxt;
      dz_r <= ctrl_i.dz;
    end
  end

  assign out_valid = valid_r;
  assign out_result = res_r;
  assign out_a_less = lt_r;
  assign out_a_equal = eq_r;
  assign out_a_greater = gt_r;
  assign out_saturated = sat_r;
  assign out_divide_by_zero = dz_r;

endmodule

FILE: src/fixed_point_q24_8_alu_unit.sv
// fixed-point alu: one pipeline for every mode, one transaction per cycle unless stalled
// the divider is a chain of 32+FRACT_BITS cells, one quotient bit each
// the whole pipeline advances together; it holds while the output register is full and stalled
// synchronous active-low reset empties the pipeline; payload registers are not reset
// depends on fxa_pkg, fxa_front, fxa_div_cell, fxa_back
module fixed_point_q24_8_alu_unit import fxa_pkg::*; #(
  parameter int FRACT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result,
  output logic        out_a_less,
  output logic        out_a_equal,
  output logic        out_a_greater,
  output logic        out_saturated,
  output logic        out_divide_by_zero
);

  localparam int W = 32 + FRACT_BITS;

  logic en;
  ctrl_t        ctrl_c [W+1];
  logic [31:0]  res_c  [W+1];
  logic [31:0]  den_c  [W+1];
  logic [31:0]  rem_c  [W+1];
  logic [W-1:0] nq_c   [W+1];

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;
  assign rem_c[0] = 32'd0;

  fxa_front #(.FRACT_BITS(FRACT_BITS), .W(W)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_mode(in_mode),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .ctrl_o(ctrl_c[0]), .res_o(res_c[0]), .den_o(den_c[0]), .num_o(nq_c[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_cell
    fxa_div_cell #(.W(W)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctrl_i(ctrl_c[i]), .res_i(res_c[i]), .den_i(den_c[i]),
      .rem_i(rem_c[i]), .nq_i(nq_c[i]),
      .ctrl_o(ctrl_c[i+1]), .res_o(res_c[i+1]), .den_o(den_c[i+1]),
      .rem_o(rem_c[i+1]), .nq_o(nq_c[i+1])
    );
  end

  fxa_back #(.W(W)) u_back (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ctrl_i(ctrl_c[W]), .res_i(res_c[W]), .den_i(den_c[W]),
    .rem_i(rem_c[W]), .q_i(nq_c[W]),
    .out_valid(out_valid), .out_result(out_result),
    .out_a_less(out_a_less), .out_a_equal(out_a_equal),
    .out_a_greater(out_a_greater), .out_saturated(out_saturated),
    .out_divide_by_zero(out_divide_by_zero)
  );

endmodule

FILE: src/fxa_checker.sv
// port-level checks of the fixed-point alu, bound to the top level
// depends on fixed_point_q24_8_alu_unit_defines.svh
`include "fixed_point_q24_8_alu_unit_defines.svh"
module fxa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result,
  input logic        out_a_less,
  input logic        out_a_equal,
  input logic        out_a_greater,
  input logic        out_saturated,
  input logic        out_divide_by_zero
);

  `FXA_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")
  `FXA_ASSERT(a_stall_only_when_full, in_stall |-> (out_valid && out_stall), "input stalled with room")
  `FXA_ASSERT(a_cmp_onehot, out_valid |-> $onehot({out_a_less, out_a_equal, out_a_greater}), "compare flags not one-hot")
  `FXA_ASSERT(a_dz_clean, (out_valid && out_divide_by_zero) |-> (!out_saturated && out_result == 32'd0), "divide by zero result")
  `FXA_ASSERT(a_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_result)), "stalled result changed")

endmodule

bind fixed_point_q24_8_alu_unit fxa_checker u_fxa_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_result(out_result),
  .out_a_less(out_a_less), .out_a_equal(out_a_equal), .out_a_greater(out_a_greater),
  .out_saturated(out_saturated), .out_divide_by_zero(out_divide_by_zero)
);
